// ===== hdl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Calibration register map, coefficient bundle, sideband word and the fixed
// constants of the integer compensation formulas.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int NUM_CAL   = 6;
	localparam int CAL_IDX_W = 3;
	localparam int CAL_W     = 32;
	localparam int RAW_W     = 20;
	localparam int TEMP_W    = 15;
	localparam int PRESS_W   = 32;
	localparam int DIV_BITS  = 64;
	localparam int DEN_W     = 31;

	// calibration register indexes
	localparam logic [CAL_IDX_W-1:0] CAL_T1_T2 = 3'd0;
	localparam logic [CAL_IDX_W-1:0] CAL_T3_P1 = 3'd1;
	localparam logic [CAL_IDX_W-1:0] CAL_P2_P3 = 3'd2;
	localparam logic [CAL_IDX_W-1:0] CAL_P4_P5 = 3'd3;
	localparam logic [CAL_IDX_W-1:0] CAL_P6_P7 = 3'd4;
	localparam logic [CAL_IDX_W-1:0] CAL_P8_P9 = 3'd5;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;

	localparam int FINE_OFFSET = 128000;
	localparam int PRESS_FULL  = 1048576;
	localparam int PRESS_SCALE = 3125;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     fault;
	} side_t;

endpackage

// ===== hdl/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front: temperature path and pressure divisor/dividend pipeline
// Ten stages from raw readings to the signed 64-bit dividend, the divisor
// and the clamped temperature. Wide products are split in 32-bit halves.
// ----------------------------------------------------------------------------
module ptc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  ptc_pkg::cal_t               cal,
	input  logic                        valid_in,
	input  logic [ptc_pkg::RAW_W-1:0]   raw_temperature,
	input  logic [ptc_pkg::RAW_W-1:0]   raw_pressure,
	output logic                        valid_out,
	output logic [63:0]                 num,
	output logic [ptc_pkg::DEN_W-1:0]   den,
	output ptc_pkg::side_t              side
);
	import ptc_pkg::*;

	logic [10:1] v_s;

	logic signed [17:0] ta;
	logic signed [16:0] td;
	logic signed [33:0] var1_s1, dd_s1;
	logic        [20:0] pr_s1, pr_s2, pr_s3, pr_s4, pr_s5, pr_s6, pr_s7;

	logic signed [21:0] dds;
	logic signed [22:0] a1_s2;
	logic signed [37:0] bm_s2;

	logic signed [25:0] fine_s3;

	logic signed [28:0] t5;
	logic signed [20:0] tsh;
	logic signed [TEMP_W-1:0] temp_c;
	logic signed [TEMP_W-1:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [26:0] pa_s4;

	logic signed [53:0] aa_s5;
	logic signed [42:0] ap5_s5, ap2_s5;

	logic        [63:0] aa64;
	logic signed [48:0] pp6l_s6, pp3l_s6;
	logic        [31:0] pp6h_s6, pp3h_s6;
	logic        [63:0] bq_s6, aterm_s6;

	logic        [63:0] x6, x3;
	logic        [63:0] b_s7, a2_s7;

	logic        [63:0] a3;
	logic        [47:0] pp1l_s8;
	logic        [31:0] pp1h_s8;
	logic        [63:0] n_s8;

	logic        [63:0] a4;
	logic signed [DEN_W-1:0] den_s9;
	logic        [43:0] ppnl_s9;
	logic        [31:0] ppnh_s9;

	logic        [63:0] num_s10;
	logic signed [DEN_W-1:0] den_s10;
	side_t              side_s10;

	assign ta = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
	assign td = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});

	assign dds = 22'(dd_s1 >>> 12);

	assign t5  = 29'(fine_s3) * 29'sd5 + 29'sd128;
	assign tsh = 21'(t5 >>> 8);

	always_comb begin
		if (tsh < 21'(TEMP_MIN))
			temp_c = TEMP_MIN;
		else if (tsh > 21'(TEMP_MAX))
			temp_c = TEMP_MAX;
		else
			temp_c = 15'(tsh);
	end

	assign aa64 = 64'(aa_s5);
	assign x6   = 64'(pp6l_s6) + {pp6h_s6, 32'd0};
	assign x3   = 64'(pp3l_s6) + {pp3h_s6, 32'd0};
	assign a3   = a2_s7 + 64'h0000_8000_0000_0000;
	assign a4   = {16'd0, pp1l_s8} + {pp1h_s8, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[9:1], valid_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			var1_s1 <= ta * cal.t2;
			dd_s1   <= td * td;
			pr_s1   <= 21'(PRESS_FULL) - {1'b0, raw_pressure};
			// s2
			a1_s2 <= 23'(var1_s1 >>> 11);
			bm_s2 <= dds * cal.t3;
			pr_s2 <= pr_s1;
			// s3
			fine_s3 <= 26'(a1_s2) + 26'(bm_s2 >>> 14);
			pr_s3   <= pr_s2;
			// s4
			temp_s4 <= temp_c;
			pa_s4   <= 27'(fine_s3) - 27'(FINE_OFFSET);
			pr_s4   <= pr_s3;
			// s5
			aa_s5   <= pa_s4 * pa_s4;
			ap5_s5  <= pa_s4 * cal.p5;
			ap2_s5  <= pa_s4 * cal.p2;
			temp_s5 <= temp_s4;
			pr_s5   <= pr_s4;
			// s6: low 64 bits of the 64x16 products, as two partials
			pp6l_s6  <= $signed({1'b0, aa64[31:0]}) * cal.p6;
			pp6h_s6  <= aa64[63:32] * 32'(cal.p6);
			pp3l_s6  <= $signed({1'b0, aa64[31:0]}) * cal.p3;
			pp3h_s6  <= aa64[63:32] * 32'(cal.p3);
			bq_s6    <= (64'(ap5_s5) << 17) + (64'(cal.p4) << 35);
			aterm_s6 <= 64'(ap2_s5) << 12;
			temp_s6  <= temp_s5;
			pr_s6    <= pr_s5;
			// s7
			b_s7    <= x6 + bq_s6;
			a2_s7   <= 64'($signed(x3) >>> 8) + aterm_s6;
			temp_s7 <= temp_s6;
			pr_s7   <= pr_s6;
			// s8
			pp1l_s8 <= a3[31:0] * cal.p1;
			pp1h_s8 <= a3[63:32] * {16'd0, cal.p1};
			n_s8    <= {12'd0, pr_s7, 31'd0} - b_s7;
			temp_s8 <= temp_s7;
			// s9
			den_s9  <= 31'($signed(a4) >>> 33);
			ppnl_s9 <= n_s8[31:0] * 12'(PRESS_SCALE);
			ppnh_s9 <= n_s8[63:32] * 32'(PRESS_SCALE);
			temp_s9 <= temp_s8;
			// s10
			num_s10        <= {20'd0, ppnl_s9} + {ppnh_s9, 32'd0};
			den_s10        <= den_s9;
			side_s10.temp  <= temp_s9;
			side_s10.fault <= (den_s9 == '0);
		end
	end

	assign valid_out = v_s[10];
	assign num       = num_s10;
	assign den       = den_s10;
	assign side      = side_s10;

endmodule

// ===== hdl/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div: pipelined signed 64 by 31 bit divider
// Magnitude stage, one restoring step per quotient bit, then sign fix.
// Quotient truncates toward zero. A sideband word rides along.
// ----------------------------------------------------------------------------
module ptc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_in,
	input  logic [63:0]                num,
	input  logic [ptc_pkg::DEN_W-1:0]  den,
	input  ptc_pkg::side_t             side_in,
	output logic                       valid_out,
	output logic [63:0]                quot,
	output ptc_pkg::side_t             side_out
);
	import ptc_pkg::*;

	logic             v_s    [DIV_BITS+2];
	logic [DEN_W-1:0] rem_s  [DIV_BITS+1];
	logic [63:0]      q_s    [DIV_BITS+1];
	logic [DEN_W-1:0] mb_s   [DIV_BITS+1];
	logic             neg_s  [DIV_BITS+1];
	side_t            side_s [DIV_BITS+1];

	logic [DEN_W:0]   trial  [DIV_BITS];
	logic [DEN_W:0]   diff   [DIV_BITS];
	logic             take   [DIV_BITS];

	logic [63:0]      quot_s65;
	side_t            side_s65;

	always_comb begin
		for (int k = 0; k < DIV_BITS; k++) begin
			trial[k] = {rem_s[k], q_s[k][63]};
			diff[k]  = trial[k] - {1'b0, mb_s[k]};
			take[k]  = trial[k] >= {1'b0, mb_s[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_BITS + 2; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid_in;
			for (int k = 1; k < DIV_BITS + 2; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0]    <= num[63] ? (~num + 64'd1) : num;
			mb_s[0]   <= den[DEN_W-1] ? (~den + 31'd1) : den;
			rem_s[0]  <= '0;
			neg_s[0]  <= num[63] ^ den[DEN_W-1];
			side_s[0] <= side_in;
			// dividend bits shift out at the top, quotient bits in at the bottom
			for (int k = 0; k < DIV_BITS; k++) begin
				rem_s[k+1]  <= take[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
				q_s[k+1]    <= {q_s[k][62:0], take[k]};
				mb_s[k+1]   <= mb_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
			quot_s65 <= neg_s[DIV_BITS] ? (~q_s[DIV_BITS] + 64'd1) : q_s[DIV_BITS];
			side_s65 <= side_s[DIV_BITS];
		end
	end

	assign valid_out = v_s[DIV_BITS+1];
	assign quot      = quot_s65;
	assign side_out  = side_s65;

endmodule

// ===== hdl/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back: post-division pressure correction pipeline
// Five stages: p9 and p8 terms, 64-bit low product from 32-bit partials,
// final sum, p7 offset and saturation to unsigned 24.8.
// ----------------------------------------------------------------------------
module ptc_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  ptc_pkg::cal_t                      cal,
	input  logic                               valid_in,
	input  logic [63:0]                        p,
	input  ptc_pkg::side_t                     side_in,
	output logic                               valid_out,
	output logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centi,
	output logic [ptc_pkg::PRESS_W-1:0]        pressure_q24_8,
	output logic                               divide_fault
);
	import ptc_pkg::*;

	logic [5:1] v_s;

	logic        [63:0] s64;
	logic signed [48:0] pp9l_s1, pp8l_s1;
	logic        [31:0] pp9h_s1, pp8h_s1;
	logic        [63:0] p_s1, s_s1, p_s2, s_s2, p_s3, p_s4;
	side_t              side_s1, side_s2, side_s3, side_s4;

	logic        [63:0] b8;
	logic        [63:0] m_s2, b_s2, b_s3, b_s4;

	logic        [63:0] mm_s3;
	logic        [31:0] x1_s3, x2_s3;

	logic        [63:0] prod;
	logic        [63:0] a_s4;

	logic        [63:0] sum, r;
	logic        [PRESS_W-1:0] press_c;
	logic signed [TEMP_W-1:0]  temp_s5;
	logic        [PRESS_W-1:0] press_s5;
	logic                      fault_s5;

	assign s64  = 64'($signed(p) >>> 13);
	assign b8   = 64'(pp8l_s1) + {pp8h_s1, 32'd0};
	assign prod = mm_s3 + {x1_s3 + x2_s3, 32'd0};
	assign sum  = p_s4 + a_s4 + b_s4;
	assign r    = 64'($signed(sum) >>> 8) + (64'(cal.p7) << 4);

	always_comb begin
		if (side_s4.fault || r[63])
			press_c = '0;
		else if (|r[62:32])
			press_c = '1;
		else
			press_c = r[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[4:1], valid_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			pp9l_s1 <= $signed({1'b0, s64[31:0]}) * cal.p9;
			pp9h_s1 <= s64[63:32] * 32'(cal.p9);
			pp8l_s1 <= $signed({1'b0, p[31:0]}) * cal.p8;
			pp8h_s1 <= p[63:32] * 32'(cal.p8);
			p_s1    <= p;
			s_s1    <= s64;
			side_s1 <= side_in;
			// s2
			m_s2    <= 64'(pp9l_s1) + {pp9h_s1, 32'd0};
			b_s2    <= 64'($signed(b8) >>> 19);
			p_s2    <= p_s1;
			s_s2    <= s_s1;
			side_s2 <= side_s1;
			// s3: low 64 bits of m * s from three 32x32 partials
			mm_s3   <= m_s2[31:0] * s_s2[31:0];
			x1_s3   <= m_s2[63:32] * s_s2[31:0];
			x2_s3   <= m_s2[31:0] * s_s2[63:32];
			p_s3    <= p_s2;
			b_s3    <= b_s2;
			side_s3 <= side_s2;
			// s4
			a_s4    <= 64'($signed(prod) >>> 25);
			p_s4    <= p_s3;
			b_s4    <= b_s3;
			side_s4 <= side_s3;
			// s5
			temp_s5  <= side_s4.temp;
			press_s5 <= press_c;
			fault_s5 <= side_s4.fault;
		end
	end

	assign valid_out         = v_s[5];
	assign temperature_centi = temp_s5;
	assign pressure_q24_8    = press_s5;
	assign divide_fault      = fault_s5;

endmodule

// ===== hdl/pressure_temperature_compensation_top.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top: barometric sensor compensation
// Calibration registers, compensation pipeline and output register with skid.
// ----------------------------------------------------------------------------
// Takes one word of raw 20-bit temperature and pressure readings per cycle
// while in_stall is low and returns temperature in 0.01 degree (clamped to
// -40.00..85.00) and pressure in Pa as unsigned 24.8, with divide_fault set
// when the pressure divisor is zero. The datapath is a fixed 81-stage
// pipeline (10 front stages, a 66-stage divider doing one quotient bit per
// restoring stage, 5 back stages) followed by the output register, 82
// registers in all, and a new word can be accepted every cycle while
// in_stall is low. A skid register at the output lets the pipeline take one
// more step when the output stalls; in_stall rises only once the skid holds
// a word. Several front and back stages read the calibration registers
// directly, so write them only while no word is in flight.
module pressure_temperature_compensation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ptc_pkg::CAL_IDX_W-1:0]       cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ptc_pkg::RAW_W-1:0]           raw_temperature,
	input  logic [ptc_pkg::RAW_W-1:0]           raw_pressure,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ptc_pkg::TEMP_W-1:0]   temperature_centi,
	output logic [ptc_pkg::PRESS_W-1:0]         pressure_q24_8,
	output logic                                divide_fault
);
	import ptc_pkg::*;

	logic [CAL_W-1:0] cal_q [NUM_CAL];
	cal_t             cal;
	logic             en;

	logic             fv;
	logic [63:0]      fnum;
	logic [DEN_W-1:0] fden;
	side_t            fside;

	logic             dv;
	logic [63:0]      dquot;
	side_t            dside;

	logic                     bv;
	logic signed [TEMP_W-1:0] btemp;
	logic [PRESS_W-1:0]       bpress;
	logic                     bfault;

	logic                     out_valid_q, skid_valid_q;
	logic signed [TEMP_W-1:0] temp_q, skid_temp_q;
	logic [PRESS_W-1:0]       press_q, skid_press_q;
	logic                     fault_q, skid_fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAL; i++)
				cal_q[i] <= '0;
		end else if (cfg_write && cfg_index < CAL_IDX_W'(NUM_CAL)) begin
			cal_q[cfg_index] <= cfg_data;
		end
	end

	assign cal.t1 = cal_q[CAL_T1_T2][15:0];
	assign cal.t2 = $signed(cal_q[CAL_T1_T2][31:16]);
	assign cal.t3 = $signed(cal_q[CAL_T3_P1][15:0]);
	assign cal.p1 = cal_q[CAL_T3_P1][31:16];
	assign cal.p2 = $signed(cal_q[CAL_P2_P3][15:0]);
	assign cal.p3 = $signed(cal_q[CAL_P2_P3][31:16]);
	assign cal.p4 = $signed(cal_q[CAL_P4_P5][15:0]);
	assign cal.p5 = $signed(cal_q[CAL_P4_P5][31:16]);
	assign cal.p6 = $signed(cal_q[CAL_P6_P7][15:0]);
	assign cal.p7 = $signed(cal_q[CAL_P6_P7][31:16]);
	assign cal.p8 = $signed(cal_q[CAL_P8_P9][15:0]);
	assign cal.p9 = $signed(cal_q[CAL_P8_P9][31:16]);

	// whole pipeline freezes only while the skid holds a word
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.cal             (cal),
		.valid_in        (in_valid),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.valid_out       (fv),
		.num             (fnum),
		.den             (fden),
		.side            (fside)
	);

	ptc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (fv),
		.num       (fnum),
		.den       (fden),
		.side_in   (fside),
		.valid_out (dv),
		.quot      (dquot),
		.side_out  (dside)
	);

	ptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.cal               (cal),
		.valid_in          (dv),
		.p                 (dquot),
		.side_in           (dside),
		.valid_out         (bv),
		.temperature_centi (btemp),
		.pressure_q24_8    (bpress),
		.divide_fault      (bfault)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall)
				skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= bv;
		end else if (bv) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				temp_q  <= skid_temp_q;
				press_q <= skid_press_q;
				fault_q <= skid_fault_q;
			end
		end else if (!out_valid_q || !out_stall) begin
			temp_q  <= btemp;
			press_q <= bpress;
			fault_q <= bfault;
		end else begin
			skid_temp_q  <= btemp;
			skid_press_q <= bpress;
			skid_fault_q <= bfault;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_q;
	assign pressure_q24_8    = press_q;
	assign divide_fault      = fault_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without an output stall");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fault_q) |-> (press_q == '0))
		else $error("divide fault with nonzero pressure");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (temp_q >= TEMP_MIN && temp_q <= TEMP_MAX))
		else $error("temperature outside clamp range");
`endif

endmodule

// ===== dv/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker: result predictor and scoreboard for pressure compensation
// Mirrors the calibration writes, computes the compensated temperature and
// pressure for each accepted input word and compares every output word,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ptc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ptc_pkg::CAL_IDX_W-1:0]       cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]           cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [ptc_pkg::RAW_W-1:0]           raw_temperature,
	input  logic [ptc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [ptc_pkg::TEMP_W-1:0]   temperature_centi,
	input  logic [ptc_pkg::PRESS_W-1:0]         pressure_q24_8,
	input  logic                                divide_fault,
	output int                                  fail_count,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptc_pkg::*;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [PRESS_W-1:0]       press;
		logic                     fault;
	} comp_word_t;

	logic [CAL_W-1:0] cal_shadow [NUM_CAL];
	comp_word_t       comp_q [$];

	assign pending = comp_q.size();

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic comp_word_t compensate(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint a, b, d, fine, tc, p;
		comp_word_t r;
		t1 = longint'(cal_shadow[CAL_T1_T2][15:0]);
		t2 = sx16(cal_shadow[CAL_T1_T2][31:16]);
		t3 = sx16(cal_shadow[CAL_T3_P1][15:0]);
		p1 = longint'(cal_shadow[CAL_T3_P1][31:16]);
		p2 = sx16(cal_shadow[CAL_P2_P3][15:0]);
		p3 = sx16(cal_shadow[CAL_P2_P3][31:16]);
		p4 = sx16(cal_shadow[CAL_P4_P5][15:0]);
		p5 = sx16(cal_shadow[CAL_P4_P5][31:16]);
		p6 = sx16(cal_shadow[CAL_P6_P7][15:0]);
		p7 = sx16(cal_shadow[CAL_P6_P7][31:16]);
		p8 = sx16(cal_shadow[CAL_P8_P9][15:0]);
		p9 = sx16(cal_shadow[CAL_P8_P9][31:16]);
		a = (((longint'(rt) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (longint'(rt) >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		tc = (fine * 5 + 128) >>> 8;
		if (tc < -4000) tc = -4000;
		else if (tc > 8500) tc = 8500;
		r.temp = tc[TEMP_W-1:0];
		a = fine - FINE_OFFSET;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (a == 0) begin
			r.fault = 1'b1;
			r.press = '0;
		end else begin
			r.fault = 1'b0;
			p = PRESS_FULL - longint'(rp);
			p = (((p <<< 31) - b) * PRESS_SCALE);
			// most negative / -1 wraps back to itself
			if (a == -1) p = -p;
			else p = p / a;
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + a + b) >>> 8) + (p7 <<< 4);
			if (p < 0) r.press = '0;
			else if (p > 64'sh0FFFF_FFFF) r.press = '1;
			else r.press = p[31:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		comp_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAL; i++) cal_shadow[i] = '0;
			comp_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (comp_q.size() == 0) begin
					$error("unexpected output word");
					fail_count++;
				end else begin
					e = comp_q.pop_front();
					if (temperature_centi !== e.temp) begin
						$error("temperature_centi exp %0d got %0d", e.temp, temperature_centi);
						fail_count++;
					end
					if (pressure_q24_8 !== e.press) begin
						$error("pressure_q24_8 exp %0h got %0h", e.press, pressure_q24_8);
						fail_count++;
					end
					if (divide_fault !== e.fault) begin
						$error("divide_fault exp %0b got %0b", e.fault, divide_fault);
						fail_count++;
					end
				end
			end
			// words accepted this edge use the registers before this edge's write
			if (in_valid && !in_stall)
				comp_q.push_back(compensate(raw_temperature, raw_pressure));
			if (cfg_write && cfg_index < NUM_CAL)
				cal_shadow[cfg_index] = cfg_data;
		end
	end
endmodule

// ===== dv/tb_pressure_temperature_compensation_top.sv =====
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation_top: compensation block testbench
// Programs several calibration sets (zero, extremes, typical, random), sends
// directed and random raw words with random idle bursts on both sides, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ptc_pkg::*;

	localparam int LATENCY   = 82;
	localparam int CYCLE_MAX = 400000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CAL_IDX_W-1:0]       cfg_index = '0;
	logic [CAL_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [RAW_W-1:0]           raw_temperature = '0;
	logic [RAW_W-1:0]           raw_pressure = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [TEMP_W-1:0]   temperature_centi;
	logic [PRESS_W-1:0]         pressure_q24_8;
	logic                       divide_fault;
	int                         fail_count;
	int                         pending;
	int                         cycle_count = 0;
	bit                         calm = 1'b0;

	always #6 clk = ~clk;

	pressure_temperature_compensation_top dut (.*);
	ptc_checker chk (.*);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic cal_write(input logic [CAL_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_word(input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
	endtask

	// typical factory set plus variations
	task automatic load_cal(input int mode);
		logic [CAL_W-1:0] v [NUM_CAL];
		case (mode)
			0: begin
				for (int i = 0; i < NUM_CAL; i++) v[i] = '0;
			end
			1: begin
				v[CAL_T1_T2] = {16'(26435), 16'd27504};
				v[CAL_T3_P1] = {16'd36477, 16'(-1000)};
				v[CAL_P2_P3] = {16'(3024), 16'(-10685)};
				v[CAL_P4_P5] = {16'(-7), 16'(2855)};
				v[CAL_P6_P7] = {16'(15500), 16'(140)};
				v[CAL_P8_P9] = {16'(6000), 16'(-14600)};
			end
			2: begin
				for (int i = 0; i < NUM_CAL; i++) v[i] = '1;
			end
			3: begin
				for (int i = 0; i < NUM_CAL; i++) v[i] = 32'h7FFF_7FFF;
				v[CAL_T1_T2] = 32'h8000_FFFF;
				v[CAL_T3_P1] = 32'hFFFF_8000;
			end
			default: begin
				for (int i = 0; i < NUM_CAL; i++) v[i] = $urandom;
				if ($urandom_range(0, 1))
					v[CAL_T3_P1][31:16] = 16'(30000 + $urandom_range(0, 10000));
			end
		endcase
		for (int i = 0; i < NUM_CAL; i++) cal_write(i[CAL_IDX_W-1:0], v[i]);
		// index above the map is ignored
		cal_write(CAL_IDX_W'(NUM_CAL + $urandom_range(0, 1)), $urandom);
	endtask

	initial begin
		logic [RAW_W-1:0] rt, rp;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero coefficients: divisor is zero
		send_word('0, '0);
		send_word('1, '1);
		idle_input();
		drain();
		load_cal(1);
		send_word('0, '0);
		send_word('1, '1);
		send_word('0, '1);
		send_word('1, '0);
		send_word(20'd519888, 20'd415148);
		send_word(20'd100000, 20'd300000);
		send_word(20'd1000000, 20'd600000);
		send_word(20'h55555, 20'hAAAAA);
		send_word(20'hAAAAA, 20'h55555);
		idle_input();
		drain();
		for (int m = 2; m < 4; m++) begin
			load_cal(m);
			for (int k = 0; k < 6; k++) send_word(20'($urandom), 20'($urandom));
			send_word('0, '0);
			send_word('1, '1);
			idle_input();
			drain();
		end

		for (int ph = 0; ph < 8; ph++) begin
			load_cal(ph < 3 ? 1 : 4);
			if (ph == 7) calm = 1'b1;
			for (int k = 0; k < 200; k++) begin
				rt = (ph < 3) ? 20'(400000 + $urandom_range(0, 250000)) : 20'($urandom);
				rp = (ph < 3 && $urandom_range(0, 3) != 0)
					? 20'(250000 + $urandom_range(0, 250000)) : 20'($urandom);
				send_word(rt, rp);
			end
			idle_input();
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
